// ===== src/crcg_pkg.sv =====
// Package with shared types, codes and the CRC byte step for the challenge-response gate.
package crcg_pkg;

  localparam int unsigned MAX_KEY_BYTES_DEF = 8;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SHARED_KEY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPIRY_TICKS = 2'd2;

  localparam logic [3:0] KEY_LENGTH_RST = 4'd8;
  localparam logic [15:0] EXPIRY_TICKS_RST = 16'd5;

  typedef enum logic [1:0] {
    REQ_ISSUE  = 2'd0,
    REQ_SUBMIT = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STAT_ISSUED    = 3'd0,
    STAT_ACCEPTED  = 3'd1,
    STAT_NO_ACTION = 3'd2,
    STAT_REFUSED   = 3'd3,
    STAT_TICK_DONE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    DRV_NONE  = 2'd0,
    DRV_OPEN  = 2'd1,
    DRV_CLOSE = 2'd2
  } drive_e;

  localparam logic [1:0] ACT_OPEN = 2'd0;
  localparam logic [1:0] ACT_CLOSE = 2'd1;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_HASH = 2'd1,
    SEQ_FIN  = 2'd2
  } seq_state_e;

  typedef struct packed {
    logic       init;
    logic       step;
    logic [7:0] data;
  } crc_ctrl_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/crcg_crc_unit.sv =====
// Shared CRC-32 register that folds in one byte per cycle while step is high.
module crcg_crc_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crcg_pkg::crc_ctrl_t ctrl_i,
  output logic [31:0]        crc_o
);
  import crcg_pkg::*;

  logic [31:0] crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.init) begin
      crc_d = CRC_INIT;
    end else if (ctrl_i.step) begin
      crc_d = crc_byte(crc_q, ctrl_i.data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

// ===== src/crcg_seq.sv =====
// Sequencer that feeds the CRC unit, keeps the token state and forms each result.
module crcg_seq #(
  parameter int unsigned MaxKeyBytes = crcg_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               req_type_i,
  input  logic [31:0]              nonce_i,
  input  logic [31:0]              token_i,
  input  logic                     token_present_i,
  input  logic                     action_present_i,
  input  logic [1:0]               action_code_i,
  input  logic [8*MaxKeyBytes-1:0] shared_key_i,
  input  logic [3:0]               key_length_i,
  input  logic [15:0]              expiry_ticks_i,
  output crcg_pkg::crc_ctrl_t      crc_ctrl_o,
  input  logic [31:0]              crc_i,
  output logic                     done_o,
  output logic [2:0]               status_o,
  output logic [1:0]               drive_o,
  output logic [31:0]              nonce_echo_o
);
  import crcg_pkg::*;

  localparam int unsigned CntW = $clog2(MaxKeyBytes + 5);
  localparam int unsigned KeyIdxW = (MaxKeyBytes > 1) ? $clog2(MaxKeyBytes) : 1;

  seq_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] nkey_q, nkey_d;
  logic [31:0] nonce_q, nonce_d;
  logic [31:0] token_q, token_d;
  logic live_q, live_d;
  logic [15:0] expiry_q, expiry_d;
  logic done_q, done_d;
  logic [2:0] status_q, status_d;
  logic [1:0] drive_q, drive_d;
  logic [31:0] echo_q, echo_d;

  logic [CntW-1:0] nkey_sat;
  logic [CntW-1:0] nonce_pos;
  logic [KeyIdxW-1:0] key_idx;
  logic [7:0] hash_byte;
  logic match;

  assign nkey_sat = (32'(key_length_i) > MaxKeyBytes) ? CntW'(MaxKeyBytes)
                                                      : CntW'(key_length_i);
  assign nonce_pos = cnt_q - nkey_q;
  assign key_idx = cnt_q[KeyIdxW-1:0];
  assign hash_byte = (cnt_q < nkey_q) ? shared_key_i[8*key_idx +: 8]
                                      : nonce_q[8*nonce_pos[1:0] +: 8];
  assign match = live_q && token_present_i && (token_i == token_q);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    nkey_d = nkey_q;
    nonce_d = nonce_q;
    token_d = token_q;
    live_d = live_q;
    expiry_d = expiry_q;
    done_d = 1'b0;
    status_d = status_q;
    drive_d = drive_q;
    echo_d = echo_q;
    crc_ctrl_o = '{init: 1'b0, step: 1'b0, data: hash_byte};

    case (state_q)
      SEQ_IDLE: begin
        if (start) begin
          drive_d = DRV_NONE;
          echo_d = '0;
          case (req_type_i)
            REQ_ISSUE: begin
              nonce_d = nonce_i;
              nkey_d = nkey_sat;
              cnt_d = '0;
              crc_ctrl_o.init = 1'b1;
              state_d = SEQ_HASH;
            end
            REQ_SUBMIT: begin
              done_d = 1'b1;
              if (match) begin
                if (action_present_i) begin
                  status_d = STAT_ACCEPTED;
                  if (action_code_i == ACT_OPEN) begin
                    drive_d = DRV_OPEN;
                  end else if (action_code_i == ACT_CLOSE) begin
                    drive_d = DRV_CLOSE;
                  end
                end else begin
                  status_d = STAT_NO_ACTION;
                end
              end else begin
                status_d = STAT_REFUSED;
              end
              live_d = 1'b0;
              expiry_d = '0;
            end
            REQ_TICK: begin
              done_d = 1'b1;
              status_d = STAT_TICK_DONE;
              if (live_q) begin
                if (expiry_q <= 16'd1) begin
                  live_d = 1'b0;
                  expiry_d = '0;
                end else begin
                  expiry_d = expiry_q - 16'd1;
                end
              end
            end
            default: begin
              done_d = 1'b1;
              status_d = STAT_TICK_DONE;
            end
          endcase
        end
      end
      SEQ_HASH: begin
        crc_ctrl_o.step = 1'b1;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == nkey_q + CntW'(3)) begin
          state_d = SEQ_FIN;
        end
      end
      SEQ_FIN: begin
        token_d = ~crc_i;
        live_d = 1'b1;
        expiry_d = expiry_ticks_i;
        done_d = 1'b1;
        status_d = STAT_ISSUED;
        drive_d = DRV_NONE;
        echo_d = nonce_q;
        state_d = SEQ_IDLE;
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      cnt_q <= '0;
      nkey_q <= '0;
      token_q <= '0;
      live_q <= 1'b0;
      expiry_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      nkey_q <= nkey_d;
      token_q <= token_d;
      live_q <= live_d;
      expiry_q <= expiry_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nonce_q <= nonce_d;
    status_q <= status_d;
    drive_q <= drive_d;
    echo_q <= echo_d;
  end

  assign busy = (state_q != SEQ_IDLE);
  assign done_o = done_q;
  assign status_o = status_q;
  assign drive_o = drive_q;
  assign nonce_echo_o = echo_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SEQ_HASH |-> cnt_q <= nkey_q + CntW'(3))
    else $error("byte counter ran past the last nonce byte");

  a_dead_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !live_q |-> expiry_q == '0)
    else $error("expiry count nonzero with no live token");

  a_issue_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && status_q == STAT_ISSUED |-> live_q)
    else $error("challenge issued without a live token");

  a_drive_only_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && status_q != STAT_ACCEPTED |-> drive_q == DRV_NONE)
    else $error("drive set on a result that is not an accepted submit");

  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SEQ_FIN |=> done_q && state_q == SEQ_IDLE)
    else $error("hash finish did not produce a result");

endmodule

// ===== src/crc32_challenge_response_gate_unit.sv =====
// Top level of the CRC-32 challenge-response gate with its configuration registers.
//
//   Channel  | Handshake            | Beat
//   request  | start, busy          | req_type_i, nonce_i, token_i, token_present_i,
//            |                      | action_present_i, action_code_i
//   result   | done_o (strobe)      | status_o, drive_o, nonce_echo_o
//   config   | cfg_we_i, cfg_idx_i  | cfg_wdata_i
//
// A submit, tick or no-op request gives its result in the cycle after it is taken.
// A challenge loads the CRC register, folds in the key bytes and the four nonce bytes,
// one CRC byte per cycle through the single CRC register, and stores the token. busy
// stays high while the CRC runs. Reset loads the register defaults and clears all
// state but nonce, status, drive and echo. The result strobe lasts one cycle and the receiver cannot stall it.
module crc32_challenge_response_gate_unit #(
  parameter int unsigned MaxKeyBytes = crcg_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      req_type_i,
  input  logic [31:0]                     nonce_i,
  input  logic [31:0]                     token_i,
  input  logic                            token_present_i,
  input  logic                            action_present_i,
  input  logic [1:0]                      action_code_i,
  input  logic                            cfg_we_i,
  input  logic [crcg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [crcg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                            done_o,
  output logic [2:0]                      status_o,
  output logic [1:0]                      drive_o,
  output logic [31:0]                     nonce_echo_o
);
  import crcg_pkg::*;

  logic [8*MaxKeyBytes-1:0] key_q;
  logic [3:0] key_len_q;
  logic [15:0] expiry_ticks_q;
  crc_ctrl_t crc_ctrl;
  logic [31:0] crc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      key_len_q <= KEY_LENGTH_RST;
      expiry_ticks_q <= EXPIRY_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SHARED_KEY: key_q <= cfg_wdata_i[8*MaxKeyBytes-1:0];
        REG_KEY_LENGTH: key_len_q <= cfg_wdata_i[3:0];
        REG_EXPIRY_TICKS: expiry_ticks_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  crcg_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .crc_o  (crc)
  );

  crcg_seq #(
    .MaxKeyBytes(MaxKeyBytes)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .nonce_i          (nonce_i),
    .token_i          (token_i),
    .token_present_i  (token_present_i),
    .action_present_i (action_present_i),
    .action_code_i    (action_code_i),
    .shared_key_i     (key_q),
    .key_length_i     (key_len_q),
    .expiry_ticks_i   (expiry_ticks_q),
    .crc_ctrl_o       (crc_ctrl),
    .crc_i            (crc),
    .done_o           (done_o),
    .status_o         (status_o),
    .drive_o          (drive_o),
    .nonce_echo_o     (nonce_echo_o)
  );

endmodule
